// ----- rtl/core/tevq_pkg.sv -----
// tevq_pkg: action and result codes shared by the timed event queue
// no dependencies
package tevq_pkg;

  localparam logic [1:0] ACT_INSERT  = 2'd0;
  localparam logic [1:0] ACT_CANCEL  = 2'd1;
  localparam logic [1:0] ACT_ADVANCE = 2'd2;
  localparam logic [1:0] ACT_QUERY   = 2'd3;

  localparam logic [2:0] KIND_INSERTED = 3'd0;
  localparam logic [2:0] KIND_REJECTED = 3'd1;
  localparam logic [2:0] KIND_FIRED    = 3'd2;
  localparam logic [2:0] KIND_DONE     = 3'd3;
  localparam logic [2:0] KIND_ANSWER   = 3'd4;

  localparam int unsigned TIME_BITS = 32;

endpackage

// ----- rtl/core/timed_event_queue.sv -----
// timed_event_queue: time-sorted store of pending events with a current time
// depends on tevq_pkg and tevq_ram
//
// Usage: drive action_i and its operands with start_i high; the item is taken
// at a rising edge where busy_o is low. Every result shows for one cycle with
// valid_o high and cannot be held off; last_o marks the final result of an item.
// Insert places current time plus delay (saturating) ahead of equal due times;
// a full store gives a rejected result. Cancel removes all events whose tag
// matches and whose callback matches (callback 0 matches any). Advance sends one
// fired result per due event, earliest first, then a done result. Query answers
// with the remaining time of the first exact match.
// Operation: the store is one RAM with registered read, visited one entry at a
// time by a small sequencer that reads an entry and then evaluates it. Insert
// walks from the back over the entries at or after the new due time, moving each
// up one place; cancel visits every entry and query stops at the first match;
// advance reads the due events and then moves the remaining ones to the front.
// With an empty store every item is answered straight from the idle state.
// Reset empties the store and sets current time to zero; no clearing pass.
module timed_event_queue #(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned CALLBACK_BITS = 8,
  parameter int unsigned TAG_BITS      = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [1:0]                           action_i,
  input  logic [tevq_pkg::TIME_BITS-1:0]       delay_i,
  input  logic [CALLBACK_BITS-1:0]             callback_id_i,
  input  logic [TAG_BITS-1:0]                  data_tag_i,
  input  logic [tevq_pkg::TIME_BITS-1:0]       new_time_i,
  output logic                                 valid_o,
  output logic [2:0]                           result_kind_o,
  output logic [CALLBACK_BITS-1:0]             fired_callback_o,
  output logic [TAG_BITS-1:0]                  fired_tag_o,
  output logic [tevq_pkg::TIME_BITS-1:0]       event_time_o,
  output logic [tevq_pkg::TIME_BITS-1:0]       remaining_o,
  output logic                                 found_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     removed_count_o,
  output logic                                 null_callback_o,
  output logic                                 last_o
);
  import tevq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = TIME_BITS + CALLBACK_BITS + TAG_BITS;
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD    = 3'd1;
  localparam logic [2:0] ST_EV    = 3'd2;
  localparam logic [2:0] ST_INSW  = 3'd3;
  localparam logic [2:0] ST_SH_RD = 3'd4;
  localparam logic [2:0] ST_SH_EV = 3'd5;

  logic [2:0]               state_q, state_d;
  logic [1:0]               op_q, op_d;
  logic [TIME_BITS-1:0]     due_q, due_d;
  logic [TIME_BITS-1:0]     ntime_q, ntime_d;
  logic [CALLBACK_BITS-1:0] cb_q, cb_d;
  logic [TAG_BITS-1:0]      tag_q, tag_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic [CW-1:0]            aux_q, aux_d;
  logic [CW-1:0]            count_q, count_d;
  logic [TIME_BITS-1:0]     time_q, time_d;

  logic                     vld_q, vld_d;
  logic [2:0]               kind_q, kind_d;
  logic [CALLBACK_BITS-1:0] fcb_q, fcb_d;
  logic [TAG_BITS-1:0]      ftag_q, ftag_d;
  logic [TIME_BITS-1:0]     etime_q, etime_d;
  logic [TIME_BITS-1:0]     rem_q, rem_d;
  logic                     found_q, found_d;
  logic [CW-1:0]            rc_q, rc_d;
  logic                     null_q, null_d;
  logic                     last_q, last_d;

  logic                     we;
  logic [AW-1:0]            waddr;
  logic [EW-1:0]            wdata;
  logic [EW-1:0]            rdata;
  logic [TIME_BITS-1:0]     r_due;
  logic [CALLBACK_BITS-1:0] r_cb;
  logic [TAG_BITS-1:0]      r_tag;
  logic [TIME_BITS:0]       sum;
  logic [TIME_BITS-1:0]     new_due;
  logic [CW-1:0]            idx_inc;
  logic                     cancel_hit;
  logic [CW-1:0]            kept_next;

  tevq_ram #(
    .Width (EW),
    .Depth (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign r_due      = rdata[EW-1 -: TIME_BITS];
  assign r_cb       = rdata[TAG_BITS +: CALLBACK_BITS];
  assign r_tag      = rdata[TAG_BITS-1:0];
  assign sum        = {1'b0, time_q} + {1'b0, delay_i};
  assign new_due    = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  assign idx_inc    = idx_q + 1'b1;
  assign cancel_hit = ((cb_q == '0) || (r_cb == cb_q)) && (r_tag == tag_q);
  assign kept_next  = cancel_hit ? aux_q : aux_q + 1'b1;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    due_d   = due_q;
    ntime_d = ntime_q;
    cb_d    = cb_q;
    tag_d   = tag_q;
    idx_d   = idx_q;
    aux_d   = aux_q;
    count_d = count_q;
    time_d  = time_q;
    we      = 1'b0;
    waddr   = '0;
    wdata   = rdata;
    vld_d   = 1'b0;
    kind_d  = KIND_DONE;
    fcb_d   = '0;
    ftag_d  = '0;
    etime_d = '0;
    rem_d   = '0;
    found_d = 1'b0;
    rc_d    = '0;
    null_d  = 1'b0;
    last_d  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d    = action_i;
          due_d   = new_due;
          ntime_d = new_time_i;
          cb_d    = callback_id_i;
          tag_d   = data_tag_i;
          idx_d   = '0;
          aux_d   = '0;
          unique case (action_i)
            ACT_INSERT: begin
              if (count_q == FULL) begin
                vld_d   = 1'b1;
                kind_d  = KIND_REJECTED;
                etime_d = new_due;
              end else if (count_q == '0) begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = {new_due, callback_id_i, data_tag_i};
                count_d = count_q + 1'b1;
                vld_d   = 1'b1;
                kind_d  = KIND_INSERTED;
                etime_d = new_due;
              end else begin
                idx_d   = count_q - 1'b1;
                state_d = ST_RD;
              end
            end
            ACT_CANCEL: begin
              if (count_q == '0) begin
                vld_d = 1'b1;
              end else begin
                state_d = ST_RD;
              end
            end
            ACT_ADVANCE: begin
              if (count_q == '0) begin
                time_d = new_time_i;
                vld_d  = 1'b1;
              end else begin
                state_d = ST_RD;
              end
            end
            ACT_QUERY: begin
              if (count_q == '0) begin
                vld_d  = 1'b1;
                kind_d = KIND_ANSWER;
              end else begin
                state_d = ST_RD;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_RD: begin
        state_d = ST_EV;
      end
      ST_EV: begin
        unique case (op_q)
          ACT_INSERT: begin
            we    = 1'b1;
            waddr = idx_inc[AW-1:0];
            if (r_due >= due_q) begin
              if (idx_q == '0) begin
                state_d = ST_INSW;
              end else begin
                idx_d   = idx_q - 1'b1;
                state_d = ST_RD;
              end
            end else begin
              wdata   = {due_q, cb_q, tag_q};
              count_d = count_q + 1'b1;
              vld_d   = 1'b1;
              kind_d  = KIND_INSERTED;
              etime_d = due_q;
              state_d = ST_IDLE;
            end
          end
          ACT_CANCEL: begin
            we    = !cancel_hit;
            waddr = aux_q[AW-1:0];
            aux_d = kept_next;
            idx_d = idx_inc;
            if (idx_inc == count_q) begin
              count_d = kept_next;
              vld_d   = 1'b1;
              rc_d    = count_q - kept_next;
              state_d = ST_IDLE;
            end else begin
              state_d = ST_RD;
            end
          end
          ACT_ADVANCE: begin
            if (r_due <= ntime_q) begin
              vld_d   = 1'b1;
              kind_d  = KIND_FIRED;
              fcb_d   = r_cb;
              ftag_d  = r_tag;
              etime_d = r_due;
              null_d  = (r_cb == '0);
              last_d  = 1'b0;
              idx_d   = idx_inc;
              aux_d   = idx_inc;
              state_d = (idx_inc == count_q) ? ST_SH_RD : ST_RD;
            end else begin
              state_d = ST_SH_RD;
            end
          end
          ACT_QUERY: begin
            if ((r_cb == cb_q) && (r_tag == tag_q)) begin
              vld_d   = 1'b1;
              kind_d  = KIND_ANSWER;
              rem_d   = r_due - time_q;
              found_d = 1'b1;
              state_d = ST_IDLE;
            end else if (idx_inc == count_q) begin
              vld_d   = 1'b1;
              kind_d  = KIND_ANSWER;
              state_d = ST_IDLE;
            end else begin
              idx_d   = idx_inc;
              state_d = ST_RD;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_INSW: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = {due_q, cb_q, tag_q};
        count_d = count_q + 1'b1;
        vld_d   = 1'b1;
        kind_d  = KIND_INSERTED;
        etime_d = due_q;
        state_d = ST_IDLE;
      end
      ST_SH_RD: begin
        if ((idx_q == count_q) || (aux_q == '0)) begin
          count_d = count_q - aux_q;
          time_d  = ntime_q;
          vld_d   = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SH_EV;
        end
      end
      ST_SH_EV: begin
        we      = 1'b1;
        waddr   = AW'(idx_q - aux_q);
        idx_d   = idx_inc;
        state_d = ST_SH_RD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      time_q  <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      time_q  <= time_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    due_q   <= due_d;
    ntime_q <= ntime_d;
    cb_q    <= cb_d;
    tag_q   <= tag_d;
    idx_q   <= idx_d;
    aux_q   <= aux_d;
    kind_q  <= kind_d;
    fcb_q   <= fcb_d;
    ftag_q  <= ftag_d;
    etime_q <= etime_d;
    rem_q   <= rem_d;
    found_q <= found_d;
    rc_q    <= rc_d;
    null_q  <= null_d;
    last_q  <= last_d;
  end

  assign busy_o           = (state_q != ST_IDLE);
  assign valid_o          = vld_q;
  assign result_kind_o    = kind_q;
  assign fired_callback_o = fcb_q;
  assign fired_tag_o      = ftag_q;
  assign event_time_o     = etime_q;
  assign remaining_o      = rem_q;
  assign found_o          = found_q;
  assign removed_count_o  = rc_q;
  assign null_callback_o  = null_q;
  assign last_o           = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL)
    else $error("entry count beyond depth");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || valid_o))
    else $error("accepted item neither started nor answered");

  a_not_last_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> (result_kind_o == KIND_FIRED))
    else $error("only fired results may precede the last result");

  a_null_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (result_kind_o == KIND_FIRED)) |-> (null_callback_o == (fired_callback_o == '0)))
    else $error("null callback flag mismatch");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> !busy_o)
    else $error("last result while still busy");

endmodule

// ----- rtl/core/tevq_ram.sv -----
// tevq_ram: generic single write, single read RAM with registered read data
// no dependencies
module tevq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sim/testbench.sv -----
// testbench: random and directed check of timed_event_queue against a built-in predictor
// depends on tevq_pkg and the timed_event_queue rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tevq_pkg::*;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned RC_BITS = $clog2(DEPTH + 1);
  localparam int unsigned LIMIT   = 400000;

  typedef struct {
    logic [1:0]  action;
    logic [31:0] delay;
    logic [7:0]  cb;
    logic [15:0] tag;
    logic [31:0] ntime;
    bit          hold;
  } item_t;

  typedef struct {
    logic [2:0]         kind;
    logic [7:0]         cb;
    logic [15:0]        tag;
    logic [31:0]        etime;
    logic [31:0]        rem;
    logic               found;
    logic [RC_BITS-1:0] rc;
    logic               nullcb;
    logic               last;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [1:0] action_i = '0;
  logic [31:0] delay_i = '0;
  logic [7:0] callback_id_i = '0;
  logic [15:0] data_tag_i = '0;
  logic [31:0] new_time_i = '0;
  logic busy_o, valid_o, found_o, null_callback_o, last_o;
  logic [2:0] result_kind_o;
  logic [7:0] fired_callback_o;
  logic [15:0] fired_tag_o;
  logic [31:0] event_time_o, remaining_o;
  logic [RC_BITS-1:0] removed_count_o;

  timed_event_queue dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  item_t   pending_items[$];
  result_t expected_results[$];
  int      errors = 0;
  bit      drained = 1'b1;
  int      cycles = 0;

  // predictor state
  logic [31:0] ev_due[DEPTH];
  logic [7:0]  ev_cb[DEPTH];
  logic [15:0] ev_tag[DEPTH];
  int          ev_count = 0;
  logic [31:0] now_time = '0;

  function automatic result_t blank_result(logic [2:0] kind);
    result_t r;
    r = '{default: '0};
    r.kind = kind;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic predict_results(item_t it);
    result_t r;
    logic [32:0] sum;
    logic [31:0] due;
    int i, j, kept, n;
    bit hit;
    case (it.action)
      ACT_INSERT: begin
        sum = {1'b0, now_time} + {1'b0, it.delay};
        due = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (ev_count >= DEPTH) begin
          r = blank_result(KIND_REJECTED);
        end else begin
          i = 0;
          while (i < ev_count && ev_due[i] < due) i++;
          for (j = ev_count; j > i; j--) begin
            ev_due[j] = ev_due[j-1];
            ev_cb[j]  = ev_cb[j-1];
            ev_tag[j] = ev_tag[j-1];
          end
          ev_due[i] = due;
          ev_cb[i]  = it.cb;
          ev_tag[i] = it.tag;
          ev_count++;
          r = blank_result(KIND_INSERTED);
        end
        r.etime = due;
        expected_results.push_back(r);
      end
      ACT_CANCEL: begin
        kept = 0;
        for (i = 0; i < ev_count; i++) begin
          if (!((it.cb == 0 || ev_cb[i] == it.cb) && ev_tag[i] == it.tag)) begin
            ev_due[kept] = ev_due[i];
            ev_cb[kept]  = ev_cb[i];
            ev_tag[kept] = ev_tag[i];
            kept++;
          end
        end
        r = blank_result(KIND_DONE);
        r.rc = RC_BITS'(ev_count - kept);
        ev_count = kept;
        expected_results.push_back(r);
      end
      ACT_ADVANCE: begin
        n = 0;
        while (n < ev_count && ev_due[n] <= it.ntime) begin
          r = blank_result(KIND_FIRED);
          r.cb = ev_cb[n];
          r.tag = ev_tag[n];
          r.etime = ev_due[n];
          r.nullcb = (ev_cb[n] == 0);
          r.last = 1'b0;
          expected_results.push_back(r);
          n++;
        end
        for (i = n; i < ev_count; i++) begin
          ev_due[i-n] = ev_due[i];
          ev_cb[i-n]  = ev_cb[i];
          ev_tag[i-n] = ev_tag[i];
        end
        ev_count -= n;
        now_time = it.ntime;
        expected_results.push_back(blank_result(KIND_DONE));
      end
      default: begin
        r = blank_result(KIND_ANSWER);
        hit = 1'b0;
        for (i = 0; i < ev_count; i++) begin
          if (!hit && ev_cb[i] == it.cb && ev_tag[i] == it.tag) begin
            hit = 1'b1;
            r.found = 1'b1;
            r.rem = ev_due[i] - now_time;
          end
        end
        expected_results.push_back(r);
      end
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, act_v);
    end
  endtask

  // monitor and predictor
  always @(posedge clk_i) begin
    item_t   it;
    result_t e;
    if (rst_ni) begin
      if (valid_o) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual kind %0d",
                   $realtime, result_kind_o);
        end else begin
          e = expected_results.pop_front();
          check_field("result_kind", e.kind, result_kind_o);
          check_field("fired_callback", e.cb, fired_callback_o);
          check_field("fired_tag", e.tag, fired_tag_o);
          check_field("event_time", e.etime, event_time_o);
          check_field("remaining", e.rem, remaining_o);
          check_field("found", e.found, found_o);
          check_field("removed_count", e.rc, removed_count_o);
          check_field("null_callback", e.nullcb, null_callback_o);
          check_field("last", e.last, last_o);
        end
      end
      if (start_i && !busy_o) begin
        it.action = action_i;
        it.delay = delay_i;
        it.cb = callback_id_i;
        it.tag = data_tag_i;
        it.ntime = new_time_i;
        it.hold = 1'b0;
        predict_results(it);
      end
      drained <= (expected_results.size() == 0);
    end
  end

  // driver
  int gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    item_t it;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || !busy_o) begin
      if (gap > 0) begin
        gap <= gap - 1;
        start_i <= 1'b0;
      end else if (pending_items.size() == 0) begin
        start_i <= 1'b0;
      end else if (pending_items[0].hold && (start_i || !drained)) begin
        start_i <= 1'b0;
      end else begin
        it = pending_items.pop_front();
        action_i <= it.action;
        delay_i <= it.delay;
        callback_id_i <= it.cb;
        data_tag_i <= it.tag;
        new_time_i <= it.ntime;
        start_i <= 1'b1;
        if (pending_items.size() > 60 && $urandom_range(0, 3) == 0)
          gap <= $urandom_range(1, 9);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  logic [31:0] plan_time = '0;

  task automatic add_item(logic [1:0] a, logic [31:0] d, logic [7:0] c, logic [15:0] t,
                          logic [31:0] nt, bit h);
    item_t it;
    it = '{action: a, delay: d, cb: c, tag: t, ntime: nt, hold: h};
    if (a == ACT_ADVANCE) plan_time = nt;
    pending_items.push_back(it);
  endtask

  initial begin
    int k, sel;
    logic [7:0] c;
    logic [15:0] t;
    // directed
    add_item(ACT_QUERY, 0, 0, 0, 0, 0);
    add_item(ACT_ADVANCE, 0, 0, 0, 0, 0);
    add_item(ACT_INSERT, 0, 0, 0, 0, 0);
    add_item(ACT_INSERT, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 0, 0);
    add_item(ACT_INSERT, 5, 1, 1, 0, 0);
    add_item(ACT_INSERT, 5, 2, 1, 0, 0);
    add_item(ACT_QUERY, 0, 1, 1, 0, 0);
    add_item(ACT_QUERY, 0, 0, 0, 0, 0);
    add_item(ACT_QUERY, 0, 0, 1, 0, 0);
    for (k = 0; k < 13; k++) add_item(ACT_INSERT, 10 + k, k + 3, k, 0, 0);
    add_item(ACT_INSERT, 1, 9, 9, 0, 0);
    add_item(ACT_CANCEL, 0, 0, 1, 0, 0);
    add_item(ACT_CANCEL, 0, 3, 16'h0700, 0, 0);
    add_item(ACT_ADVANCE, 0, 0, 0, 12, 0);
    add_item(ACT_ADVANCE, 0, 0, 0, 3, 1);
    add_item(ACT_ADVANCE, 0, 0, 0, 32'hFFFF_FFFF, 0);
    add_item(ACT_INSERT, 32'hFFFF_FFFF, 0, 16'hFFFF, 0, 0);
    add_item(ACT_ADVANCE, 0, 0, 0, 0, 0);
    add_item(ACT_ADVANCE, 0, 0, 0, 32'hFFFF_FFFF, 0);
    add_item(ACT_ADVANCE, 0, 0, 0, 0, 0);
    // random
    for (k = 0; k < 370; k++) begin
      sel = $urandom_range(0, 99);
      c = ($urandom_range(0, 3) == 0) ? 8'd0 :
          ($urandom_range(0, 1) ? 8'($urandom_range(1, 4)) : 8'($urandom));
      t = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      if (sel < 45)
        add_item(ACT_INSERT, ($urandom_range(0, 6) == 0) ? $urandom : $urandom_range(0, 60),
                 c, t, $urandom, $urandom_range(0, 49) == 0);
      else if (sel < 55)
        add_item(ACT_CANCEL, $urandom, c, t, $urandom, 0);
      else if (sel < 80)
        add_item(ACT_ADVANCE, $urandom, c, t,
                 ($urandom_range(0, 6) == 0) ? $urandom : plan_time + $urandom_range(0, 40),
                 $urandom_range(0, 49) == 0);
      else
        add_item(ACT_QUERY, $urandom, c, t, $urandom, 0);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_items.size() == 0);
    @(posedge clk_i);
    while (start_i || !drained) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/tevq_pkg.sv
rtl/core/tevq_ram.sv
rtl/core/timed_event_queue.sv
sim/testbench.sv
